// ===== design/fpwfa_pkg.sv =====
// Package for the fixed-partition worst-fit allocator.
// Request and status codes, default sizes, sequencer state and compare result types.
// No dependencies.
package fpwfa_pkg;

    localparam int DEF_MAX_SLOTS = 16;
    localparam int DEF_SIZE_BITS = 20;
    localparam int PID_W         = 16;
    localparam int TOTAL_MEM_W   = 20;
    localparam logic [TOTAL_MEM_W-1:0] TOTAL_MEM_RESET = 20'hFFFFF;

    localparam logic [1:0] REQ_DEFINE = 2'd0;
    localparam logic [1:0] REQ_ALLOC  = 2'd1;
    localparam logic [1:0] REQ_FREE   = 2'd2;

    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEF_REJ  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FIT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_ID    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    typedef struct packed {
        logic fit;
        logic take;
        logic hit;
    } cmp_res_t;

endpackage

// ===== design/fpwfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpwfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/fpwfa_cmp.sv =====
// Shared compare unit: checks one partition entry against the pending request.
// Depends on fpwfa_pkg.
module fpwfa_cmp import fpwfa_pkg::*; #(
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic [SIZE_BITS-1:0] e_size,
    input  logic [PID_W-1:0]     e_owner,
    input  logic                 e_busy,
    input  logic [SIZE_BITS-1:0] req_size,
    input  logic [PID_W-1:0]     req_pid,
    input  logic                 found,
    input  logic [SIZE_BITS-1:0] best_size,
    output cmp_res_t             res
);

    always_comb
    begin
        res.fit  = (e_size >= req_size);
        res.take = res.fit && !e_busy && (!found || (e_size > best_size));
        res.hit  = e_busy && (e_owner == req_pid);
    end

endmodule

// ===== design/fixed_partition_worst_fit_allocator_top.sv =====
// Fixed-partition worst-fit allocator, top level with the request sequencer.
// Define and the reserved code go straight to the result stage; allocate and free scan the table
// one entry per cycle with one compare (a free stops after its hit), then go to the result stage.
// A request is taken only in idle, once the prior result is registered; an m_tready stall delays that.
// Reset: async active low; no partitions, no busy slots, next pid 0, total memory all ones in at most the low 20 bits.
// Depends on fpwfa_pkg, fpwfa_ram, fpwfa_cmp.
module fixed_partition_worst_fit_allocator_top import fpwfa_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int SIZE_BITS = DEF_SIZE_BITS,
    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int IN_W   = ((SIZE_BITS + PID_W + 7) / 8) * 8,
    localparam int OUT_W  = ((IDX_W + PID_W + 4 * SIZE_BITS + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SIZE_BITS-1:0] cfg_wdata,    // total_memory
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,      // req_size, req_pid
    input  logic [1:0]           s_tuser,      // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,      // slot_index, granted_pid, slack_in_slot,
                                               // free_slot_total, unused_total,
                                               // unpartitioned_left
    output logic [STATUS_W-1:0]  m_tuser       // status
);

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int ENT_W = PID_W + 2 * SIZE_BITS;
    localparam logic [SIZE_BITS-1:0] TOTAL_RST =
        (SIZE_BITS >= TOTAL_MEM_W) ? SIZE_BITS'(TOTAL_MEM_RESET) : '1;

    state_t               state_reg, state_next;
    logic [SIZE_BITS-1:0] total_reg, total_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic [SIZE_BITS-1:0] free_sum_reg, free_sum_next;
    logic [SIZE_BITS-1:0] unused_reg, unused_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PID_W-1:0]     pid_reg, pid_next;
    logic [MAX_SLOTS-1:0] busy_reg, busy_next;

    logic [1:0]           rtype_reg, rtype_next;
    logic [SIZE_BITS-1:0] rsize_reg, rsize_next;
    logic [PID_W-1:0]     rpid_reg, rpid_next;

    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 found_reg, found_next;
    logic                 any_fit_reg, any_fit_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;
    logic [SIZE_BITS-1:0] best_used_reg, best_used_next;

    logic                 ov_reg, ov_next;
    logic [STATUS_W-1:0]  o_status_reg, o_status_next;
    logic [IDX_W-1:0]     o_idx_reg, o_idx_next;
    logic [PID_W-1:0]     o_pid_reg, o_pid_next;
    logic [SIZE_BITS-1:0] o_slack_reg, o_slack_next;
    logic [SIZE_BITS-1:0] o_free_reg, o_free_next;
    logic [SIZE_BITS-1:0] o_unused_reg, o_unused_next;
    logic [SIZE_BITS-1:0] o_left_reg, o_left_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic [SIZE_BITS-1:0] e_size, e_used;
    logic [PID_W-1:0]     e_owner;
    logic                 issue;
    cmp_res_t             cmp_res;

    assign e_size  = ram_rdata[SIZE_BITS-1:0];
    assign e_used  = ram_rdata[2*SIZE_BITS-1:SIZE_BITS];
    assign e_owner = ram_rdata[ENT_W-1:2*SIZE_BITS];
    assign issue   = (scan_reg < count_reg);

    fpwfa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    fpwfa_cmp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_cmp (
        .e_size    (e_size),
        .e_owner   (e_owner),
        .e_busy    (busy_reg[chk_idx_reg]),
        .req_size  (rsize_reg),
        .req_pid   (rpid_reg),
        .found     (found_reg),
        .best_size (best_size_reg),
        .res       (cmp_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        left_next      = left_reg;
        free_sum_next  = free_sum_reg;
        unused_next    = unused_reg;
        count_next     = count_reg;
        pid_next       = pid_reg;
        busy_next      = busy_reg;
        rtype_next     = rtype_reg;
        rsize_next     = rsize_reg;
        rpid_next      = rpid_reg;
        scan_next      = scan_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        any_fit_next   = any_fit_reg;
        hit_next       = hit_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        best_used_next = best_used_reg;
        ov_next        = ov_reg;
        o_status_next  = o_status_reg;
        o_idx_next     = o_idx_reg;
        o_pid_next     = o_pid_reg;
        o_slack_next   = o_slack_reg;
        o_free_next    = o_free_reg;
        o_unused_next  = o_unused_reg;
        o_left_next    = o_left_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        s_tready       = (state_reg == S_IDLE);

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_we)
        begin
            total_next = cfg_wdata;
            if (count_reg == '0)
            begin
                left_next = cfg_wdata;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    rtype_next   = s_tuser;
                    rsize_next   = s_tdata[SIZE_BITS-1:0];
                    rpid_next    = s_tdata[SIZE_BITS+PID_W-1:SIZE_BITS];
                    scan_next    = '0;
                    chk_vld_next = 1'b0;
                    found_next   = 1'b0;
                    any_fit_next = 1'b0;
                    hit_next     = 1'b0;
                    if (s_tuser inside {REQ_ALLOC, REQ_FREE})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SCAN:
            begin
                chk_vld_next = issue;
                chk_idx_next = scan_reg[IDX_W-1:0];
                if (issue)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (!issue && !chk_vld_reg)
                begin
                    state_next = S_FIN;
                end
                if (chk_vld_reg)
                begin
                    if (rtype_reg == REQ_ALLOC)
                    begin
                        if (cmp_res.fit)
                        begin
                            any_fit_next = 1'b1;
                        end
                        if (cmp_res.take)
                        begin
                            found_next     = 1'b1;
                            best_idx_next  = chk_idx_reg;
                            best_size_next = e_size;
                        end
                    end
                    else if (cmp_res.hit)
                    begin
                        hit_next       = 1'b1;
                        best_idx_next  = chk_idx_reg;
                        best_size_next = e_size;
                        best_used_next = e_used;
                        state_next     = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next       = 1'b1;
                    state_next    = S_IDLE;
                    o_status_next = ST_DEF_REJ;
                    o_idx_next    = '0;
                    o_pid_next    = '0;
                    o_slack_next  = '0;
                    case (rtype_reg)
                        REQ_DEFINE:
                        begin
                            if ((count_reg < CNT_W'(MAX_SLOTS)) && (rsize_reg <= left_reg))
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = count_reg[IDX_W-1:0];
                                ram_wdata     = {{PID_W{1'b0}}, {SIZE_BITS{1'b0}}, rsize_reg};
                                busy_next[count_reg[IDX_W-1:0]] = 1'b0;
                                left_next     = left_reg - rsize_reg;
                                free_sum_next = free_sum_reg + rsize_reg;
                                unused_next   = unused_reg + rsize_reg;
                                o_idx_next    = count_reg[IDX_W-1:0];
                                count_next    = count_reg + 1'b1;
                                o_status_next = ST_OK;
                            end
                        end
                        REQ_ALLOC:
                        begin
                            if (found_reg)
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = best_idx_reg;
                                ram_wdata     = {pid_reg, rsize_reg, best_size_reg};
                                busy_next[best_idx_reg] = 1'b1;
                                free_sum_next = free_sum_reg - best_size_reg;
                                unused_next   = unused_reg - rsize_reg;
                                o_idx_next    = best_idx_reg;
                                o_pid_next    = pid_reg;
                                o_slack_next  = best_size_reg - rsize_reg;
                                pid_next      = pid_reg + 1'b1;
                                o_status_next = ST_OK;
                            end
                            else if (any_fit_reg)
                            begin
                                o_status_next = ST_NO_FIT;
                            end
                            else
                            begin
                                o_status_next = ST_TOO_BIG;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (hit_reg)
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = best_idx_reg;
                                ram_wdata     = {rpid_reg, {SIZE_BITS{1'b0}}, best_size_reg};
                                busy_next[best_idx_reg] = 1'b0;
                                free_sum_next = free_sum_reg + best_size_reg;
                                unused_next   = unused_reg + best_used_reg;
                                o_idx_next    = best_idx_reg;
                                o_status_next = ST_OK;
                            end
                            else
                            begin
                                o_status_next = ST_NO_ID;
                            end
                        end
                        default:
                        begin
                            o_status_next = ST_DEF_REJ;
                        end
                    endcase
                    o_free_next   = free_sum_next;
                    o_unused_next = unused_next;
                    o_left_next   = left_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= TOTAL_RST;
            left_reg     <= TOTAL_RST;
            free_sum_reg <= '0;
            unused_reg   <= '0;
            count_reg    <= '0;
            pid_reg      <= '0;
            busy_reg     <= '0;
            scan_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            any_fit_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            left_reg     <= left_next;
            free_sum_reg <= free_sum_next;
            unused_reg   <= unused_next;
            count_reg    <= count_next;
            pid_reg      <= pid_next;
            busy_reg     <= busy_next;
            scan_reg     <= scan_next;
            chk_vld_reg  <= chk_vld_next;
            found_reg    <= found_next;
            any_fit_reg  <= any_fit_next;
            hit_reg      <= hit_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rtype_reg     <= rtype_next;
        rsize_reg     <= rsize_next;
        rpid_reg      <= rpid_next;
        chk_idx_reg   <= chk_idx_next;
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
        best_used_reg <= best_used_next;
        o_status_reg  <= o_status_next;
        o_idx_reg     <= o_idx_next;
        o_pid_reg     <= o_pid_next;
        o_slack_reg   <= o_slack_next;
        o_free_reg    <= o_free_next;
        o_unused_reg  <= o_unused_next;
        o_left_reg    <= o_left_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = OUT_W'({o_left_reg, o_unused_reg, o_free_reg, o_slack_reg,
                              o_pid_reg, o_idx_reg});

endmodule

// ===== test/fpwfa_alloc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the fixed-partition worst-fit allocator: watches config, request and result streams,
// keeps its own partition table to predict every result and compares field by field.
// Depends on fpwfa_pkg.
module fpwfa_alloc_checker import fpwfa_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [19:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [39:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic [2:0]   m_tuser,
    output int           errors,
    output int           pending,
    output int           checked
);

    localparam int PARTS     = DEF_MAX_SLOTS;
    localparam int SIZE_W    = DEF_SIZE_BITS;
    localparam int IDX_W     = 4;
    localparam int PRINT_CAP = 100;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot;
        logic [PID_W-1:0]    pid;
        logic [SIZE_W-1:0]   slack;
        logic [SIZE_W-1:0]   free_total;
        logic [SIZE_W-1:0]   unused;
        logic [SIZE_W-1:0]   unpart;
    } alloc_reply_t;

    logic [SIZE_W-1:0] part_size  [PARTS];
    logic [SIZE_W-1:0] part_used  [PARTS];
    logic [PID_W-1:0]  part_owner [PARTS];
    logic              part_busy  [PARTS];
    int                part_count;
    logic [PID_W-1:0]  next_id;
    logic [SIZE_W-1:0] mem_left;

    alloc_reply_t expected_replies [$];
    alloc_reply_t want;
    alloc_reply_t got;

    task automatic flag_mismatch(input string field, input longint seen, input longint ideal);
        errors++;
        if (errors <= PRINT_CAP)
            $display("MISMATCH result %0d %s: got %0d, expected %0d", checked, field, seen, ideal);
    endtask

    task automatic predict_partition_request(input logic [1:0] kind,
                                             input logic [SIZE_W-1:0] size,
                                             input logic [PID_W-1:0] pid,
                                             output alloc_reply_t r);
        logic        found;
        logic        any_fit;
        logic        hit;
        int          best;
        int          i;
        logic [31:0] free_sum;
        logic [31:0] unused_sum;
        r = '0;
        r.status = ST_DEF_REJ;
        found = 1'b0;
        any_fit = 1'b0;
        hit = 1'b0;
        best = 0;
        free_sum = '0;
        unused_sum = '0;
        case (kind)
            REQ_DEFINE: begin
                if (part_count < PARTS && size <= mem_left)
                begin
                    part_size[part_count]  = size;
                    part_used[part_count]  = '0;
                    part_owner[part_count] = '0;
                    part_busy[part_count]  = 1'b0;
                    mem_left = mem_left - size;
                    r.slot = part_count[IDX_W-1:0];
                    part_count++;
                    r.status = ST_OK;
                end
            end
            REQ_ALLOC: begin
                for (i = 0; i < part_count; i++)
                begin
                    if (part_size[i] >= size)
                    begin
                        any_fit = 1'b1;
                        if (!part_busy[i] && (!found || part_size[i] > part_size[best]))
                        begin
                            found = 1'b1;
                            best = i;
                        end
                    end
                end
                if (found)
                begin
                    part_busy[best]  = 1'b1;
                    part_used[best]  = size;
                    part_owner[best] = next_id;
                    r.pid   = next_id;
                    r.slack = part_size[best] - size;
                    r.slot  = best[IDX_W-1:0];
                    next_id = next_id + 1'b1;
                    r.status = ST_OK;
                end
                else
                begin
                    r.status = any_fit ? ST_NO_FIT : ST_TOO_BIG;
                end
            end
            REQ_FREE: begin
                r.status = ST_NO_ID;
                for (i = 0; i < part_count; i++)
                begin
                    // shared owner after an id wrap: lowest index goes first
                    if (!hit && part_busy[i] && part_owner[i] == pid)
                    begin
                        hit = 1'b1;
                        part_busy[i] = 1'b0;
                        part_used[i] = '0;
                        r.slot = i[IDX_W-1:0];
                        r.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        for (i = 0; i < part_count; i++)
        begin
            if (!part_busy[i])
                free_sum = free_sum + part_size[i];
            unused_sum = unused_sum + (part_size[i] - part_used[i]);
        end
        r.free_total = (free_sum > SIZE_MAX) ? SIZE_MAX : free_sum[SIZE_W-1:0];
        r.unused     = (unused_sum > SIZE_MAX) ? SIZE_MAX : unused_sum[SIZE_W-1:0];
        r.unpart     = mem_left;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PARTS; k++)
            begin
                part_size[k]  = '0;
                part_used[k]  = '0;
                part_owner[k] = '0;
                part_busy[k]  = 1'b0;
            end
            part_count = 0;
            next_id    = '0;
            mem_left   = TOTAL_MEM_RESET;
            expected_replies.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (part_count == 0)
                    mem_left = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                predict_partition_request(s_tuser, s_tdata[SIZE_W-1:0],
                                          s_tdata[SIZE_W +: PID_W], want);
                expected_replies.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.status     = m_tuser;
                got.slot       = m_tdata[IDX_W-1:0];
                got.pid        = m_tdata[IDX_W +: PID_W];
                got.slack      = m_tdata[IDX_W + PID_W +: SIZE_W];
                got.free_total = m_tdata[IDX_W + PID_W + SIZE_W +: SIZE_W];
                got.unused     = m_tdata[IDX_W + PID_W + 2 * SIZE_W +: SIZE_W];
                got.unpart     = m_tdata[IDX_W + PID_W + 3 * SIZE_W +: SIZE_W];
                if (expected_replies.size() == 0)
                begin
                    flag_mismatch("unexpected transfer, status", got.status, 0);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.status != want.status)
                        flag_mismatch("status", got.status, want.status);
                    if (got.slot != want.slot)
                        flag_mismatch("slot_index", got.slot, want.slot);
                    if (got.pid != want.pid)
                        flag_mismatch("granted_pid", got.pid, want.pid);
                    if (got.slack != want.slack)
                        flag_mismatch("slack_in_slot", got.slack, want.slack);
                    if (got.free_total != want.free_total)
                        flag_mismatch("free_slot_total", got.free_total, want.free_total);
                    if (got.unused != want.unused)
                        flag_mismatch("unused_total", got.unused, want.unused);
                    if (got.unpart != want.unpart)
                        flag_mismatch("unpartitioned_left", got.unpart, want.unpart);
                end
                checked++;
            end
            pending = expected_replies.size();
        end
    end

endmodule

// ===== test/tb_fixed_partition_worst_fit_allocator_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the fixed-partition worst-fit allocator: clock, reset, directed and random
// request streams, result back-pressure and the verdict. Depends on fpwfa_pkg, fpwfa_alloc_checker.
module tb_fixed_partition_worst_fit_allocator_top;
    import fpwfa_pkg::*;

    localparam int SIZE_W       = DEF_SIZE_BITS;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 104;
    localparam int PAD_W        = IN_W - SIZE_W - PID_W;
    localparam int RANDOM_ITEMS = 800;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;     // req_size, req_pid
    logic [1:0]        s_tuser;     // req_type
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;     // slot_index, granted_pid, slack_in_slot, free_slot_total,
                                    // unused_total, unpartitioned_left
    logic [2:0]        m_tuser;     // status

    int errors;
    int pending;
    int checked;
    int cycle_count;
    int n_define;
    int n_alloc;
    int n_free;
    int n_reserved;
    int n_cfg;
    int alloc_tries;
    logic quiet;

    fixed_partition_worst_fit_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    fpwfa_alloc_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int idle_cycles();
        return quiet ? 0 : $urandom_range(0, 4);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input logic [1:0] kind, input logic [SIZE_W-1:0] size,
                                input logic [PID_W-1:0] pid);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = kind;
        s_tdata  = {{PAD_W{1'b0}}, pid, size};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        case (kind)
            REQ_DEFINE: n_define++;
            REQ_ALLOC:  n_alloc++;
            REQ_FREE:   n_free++;
            default:    n_reserved++;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        wait (pending == 0);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_total(input logic [SIZE_W-1:0] value);
        drain_results();
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        n_cfg++;
    endtask

    // result side back-pressure
    initial
    begin : result_sink
        int wait_cycles;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            wait_cycles = idle_cycles();
            if (wait_cycles > 0)
            begin
                m_tready = 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int               n;
        int               pick;
        logic [SIZE_W-1:0] size;
        logic [PID_W-1:0]  pid;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_DEFINE;
        quiet     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table, zero memory
        write_total('0);
        send_request(REQ_ALLOC, '0, '0);
        send_request(REQ_FREE, '0, '0);
        send_request(REQ_RESERVED, SIZE_MAX, '1);
        send_request(REQ_DEFINE, 20'd1, '0);

        write_total(SIZE_MAX);
        send_request(REQ_DEFINE, '0, '0);
        // register only from here on, memory left stays
        write_total(20'($urandom_range(1, SIZE_MAX - 1)));
        send_request(REQ_DEFINE, 20'd20, '0);
        send_request(REQ_DEFINE, SIZE_MAX, '0);
        send_request(REQ_ALLOC, '0, '0);
        send_request(REQ_ALLOC, 20'd20, '0);
        send_request(REQ_ALLOC, 20'd21, '0);

        // zero-size slot taken, then frees of id 0 (the first one hits) and of an id that owns nothing
        quiet = 1'b1;
        send_request(REQ_ALLOC, '0, '0);
        send_request(REQ_FREE, '0, '0);
        send_request(REQ_FREE, '0, '0);
        send_request(REQ_FREE, '0, '0);
        send_request(REQ_FREE, '0, '1);
        quiet = 1'b0;

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 200 && n < 260) || (n >= 500 && n < 540);
            if (n == 300)
                drain_results();
            if (n == 400)
                write_total(20'($urandom));
            if (n == 650)
                write_total('0);
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    size = '0;
                else if (pick == 1)
                    size = SIZE_MAX;
                else
                    size = 20'($urandom_range(1, 16) * 4096);
                send_request(REQ_DEFINE, size, 16'($urandom));
            end
            else if (pick < 50)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    size = '0;
                else if (pick == 8)
                    size = 20'($urandom);
                else if (pick == 9)
                    size = 20'($urandom_range(1, 16) * 4096);
                else
                    size = 20'($urandom_range(0, 65536));
                alloc_tries++;
                send_request(REQ_ALLOC, size, 16'($urandom));
            end
            else if (pick < 95)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    pid = 16'(1 + alloc_tries - $urandom_range(0, 24));
                else if (pick < 17)
                    pid = 16'(1 + $urandom_range(0, alloc_tries));
                else
                    pid = 16'($urandom);
                send_request(REQ_FREE, 20'($urandom), pid);
            end
            else
            begin
                send_request(REQ_RESERVED, 20'($urandom), 16'($urandom));
            end
        end

        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d requests: %0d define, %0d allocate, %0d free, %0d reserved code",
                 n_define + n_alloc + n_free + n_reserved, n_define, n_alloc, n_free, n_reserved);
        $display("%0d results compared across %0d total_memory writes",
                 checked, n_cfg);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/fpwfa_pkg.sv
design/fpwfa_ram.sv
design/fpwfa_cmp.sv
design/fixed_partition_worst_fit_allocator_top.sv
test/fpwfa_alloc_checker.sv
test/tb_fixed_partition_worst_fit_allocator_top.sv
